@@ rtl/core/mandel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot pixel evaluator - shared definitions
// Fixed-point widths, register map, payload and divider interface types, and
// the glyph palette.
// ----------------------------------------------------------------------------
package mandel_pkg;

   // Design constants
   localparam int MAX_DIMENSION = 1024;
   localparam int FRACTION_BITS = 28;

   // Field widths fixed by the interface
   localparam int PIX_W     = 10;
   localparam int CFG_DIM_W = 11;
   localparam int LIMIT_W   = 8;
   localparam int COUNT_W   = 8;
   localparam int GLYPH_W   = 7;

   // Fixed-point word and derived arithmetic widths
   localparam int WORD_W = FRACTION_BITS + 4;
   localparam int PROD_W = 2 * WORD_W;
   localparam int SQ_W   = PROD_W - FRACTION_BITS;       // floor(a*b / 2^F)
   localparam int RI_W   = PROD_W - FRACTION_BITS + 1;   // floor(2*a*b / 2^F)
   localparam int ACC_W  = RI_W + 1;

   // Coordinate divider widths
   localparam int DIM_W     = $clog2(MAX_DIMENSION + 1);
   localparam int REM_W     = $clog2(MAX_DIMENSION);
   localparam int MAG_W     = (PIX_W + 1 > DIM_W) ? PIX_W + 1 : DIM_W;
   localparam int DIFF_W    = MAG_W + 1;
   localparam int NUM_W     = MAG_W + FRACTION_BITS + 1;
   localparam int DIV_STEPS = (NUM_W + 1) / 2;            // two quotient bits a step
   localparam int DVD_W     = 2 * DIV_STEPS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ESCAPE_BOUND =
      ACC_W'(1) <<< (FRACTION_BITS + 2);

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ITERATION_LIMIT = 2'd2;

   localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH     = 11'd60;
   localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT    = 11'd20;
   localparam logic [LIMIT_W-1:0]   RST_ITERATION_LIMIT = 8'd80;

   // Palette
   localparam int PALETTE_LEN = 12;
   localparam int PAL_W       = $clog2(PALETTE_LEN);

   localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_column;
      logic [PIX_W-1:0] pixel_row;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] iteration_count;
      logic [GLYPH_W-1:0] glyph;
   } rsp_payload_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [DIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quotient;
   } div_rsp_type;

   // ".,-~:;=!*#$@"
   function automatic logic [GLYPH_W-1:0] palette_glyph(input logic [PAL_W-1:0] idx);
      logic [GLYPH_W-1:0] g;
      case (idx)
         4'd0:    g = 7'h2E;
         4'd1:    g = 7'h2C;
         4'd2:    g = 7'h2D;
         4'd3:    g = 7'h7E;
         4'd4:    g = 7'h3A;
         4'd5:    g = 7'h3B;
         4'd6:    g = 7'h3D;
         4'd7:    g = 7'h21;
         4'd8:    g = 7'h2A;
         4'd9:    g = 7'h23;
         4'd10:   g = 7'h24;
         4'd11:   g = 7'h40;
         default: g = GLYPH_SPACE;
      endcase
      return g;
   endfunction

endpackage

@@ rtl/core/mandel_coord_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot coordinate divider
// Restoring divider, two quotient bits per cycle. Computes
// sign * (mag * 2^(F+1)) / divisor, truncated toward zero and saturated to
// the fixed-point word range.
// ----------------------------------------------------------------------------
module mandel_coord_div
   import mandel_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [DIM_W-1:0]  divisor_ff, divisor_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   word_type          result_ff, result_in;

   logic [REM_W:0]   trial1, trial2, dsor;
   logic             qbit1, qbit2;
   logic [REM_W-1:0] rem1, rem2;
   logic [DVD_W-1:0] quo_next;
   logic             pos_ovf, neg_ovf;
   logic             last_step;

   always_comb begin
      dsor   = (REM_W + 1)'(divisor_ff);
      trial1 = {rem_ff, dvd_ff[DVD_W-1]};
      qbit1  = (trial1 >= dsor);
      rem1   = qbit1 ? REM_W'(trial1 - dsor) : REM_W'(trial1);
      trial2 = {rem1, dvd_ff[DVD_W-2]};
      qbit2  = (trial2 >= dsor);
      rem2   = qbit2 ? REM_W'(trial2 - dsor) : REM_W'(trial2);
      quo_next = {quo_ff[DVD_W-3:0], qbit1, qbit2};

      // |q| may reach 2^(WORD_W-1) on the negative side only
      pos_ovf = |quo_next[DVD_W-1:WORD_W-1];
      neg_ovf = (|quo_next[DVD_W-1:WORD_W]) ||
                (quo_next[WORD_W-1] && (|quo_next[WORD_W-2:0]));
      last_step = (step_ff == STEP_W'(DIV_STEPS - 1));
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      neg_in     = neg_ff;
      divisor_in = divisor_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      result_in  = result_ff;
      if (busy_ff) begin
         dvd_in  = {dvd_ff[DVD_W-3:0], 2'b00};
         rem_in  = rem2;
         quo_in  = quo_next;
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               result_in = neg_ovf ? WORD_MIN : -$signed(quo_next[WORD_W-1:0]);
            end else begin
               result_in = pos_ovf ? WORD_MAX : $signed(quo_next[WORD_W-1:0]);
            end
         end
      end else if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         neg_in     = div_req.neg;
         divisor_in = div_req.divisor;
         dvd_in     = DVD_W'(div_req.mag) << (FRACTION_BITS + 1);
         rem_in     = '0;
         quo_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      neg_ff     <= neg_in;
      divisor_ff <= divisor_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      result_ff  <= result_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = result_ff;

endmodule

@@ rtl/core/mandelbrot_escape_time_pixel_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel evaluator - top level
// Maps a pixel to a complex point c and iterates z = z*z + c in 4.28 fixed
// point until escape or the iteration limit; returns count and glyph.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_pixel and raise start; the transaction is taken on an edge with
//   start high and busy low. busy stays high until the result is produced.
//   The result shows on rsp_result for one cycle with rsp_valid high; there is
//   no back-pressure, the receiver must take it in that cycle.
//   The APB-style csr port holds image_width (0x0), image_height (0x4) and
//   iteration_limit (0x8); write them only while busy is low.
// Timing:
//   Both coordinates go through one shared restoring divider, two quotient
//   bits per cycle. Each iteration then uses the one 32x32 multiplier three
//   times. One pixel at a time; busy drops in the cycle the result is shown,
//   so start can follow at once.
// Reset:
//   Synchronous; registers return to width 60, height 20, limit 80, the
//   sequencer goes idle and no result is pending.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top
   import mandel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  start,
   output logic                  busy,
   input  req_payload_type       req_pixel,

   output logic                  rsp_valid,
   output rsp_payload_type       rsp_result,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] S_DIV_RE = 3'd1;
   localparam logic [ST_W-1:0] S_DIV_IM = 3'd2;
   localparam logic [ST_W-1:0] S_RR     = 3'd3;
   localparam logic [ST_W-1:0] S_II     = 3'd4;
   localparam logic [ST_W-1:0] S_RI     = 3'd5;
   localparam logic [ST_W-1:0] S_ZI     = 3'd6;
   localparam logic [ST_W-1:0] S_DONE   = 3'd7;

   // Configuration registers
   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;

   // Sequencer and datapath
   logic [ST_W-1:0]          state_ff, state_in;
   logic [PIX_W-1:0]         row_ff, row_in;
   word_type                 cre_ff, cre_in;
   word_type                 cim_ff, cim_in;
   word_type                 zre_ff, zre_in;
   word_type                 zim_ff, zim_in;
   logic signed [SQ_W-1:0]   rr_ff, rr_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [PAL_W-1:0]         pal_ff, pal_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_result_ff, rsp_result_in;

   logic [DIM_W-1:0]         width_c, height_c;
   logic [PIX_W-1:0]         div_pix;
   logic [DIM_W-1:0]         div_dim;
   logic signed [DIFF_W-1:0] diff;
   word_type                 op_a, op_b;
   logic signed [SQ_W-1:0]   ii;
   logic signed [RI_W-1:0]   ri;
   logic signed [ACC_W-1:0]  mag_sq, zre_sum, zim_sum;
   logic                     escape;
   logic                     csr_write;
   logic [REG_IDX_W-1:0]     csr_idx;
   logic                     div_start;

   div_req_type div_req;
   div_rsp_type div_rsp;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (32'(d) > MAX_DIMENSION) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = DIM_W'(d);
      end
      return r;
   endfunction

   function automatic word_type sat_word(input logic signed [ACC_W-1:0] v);
      word_type r;
      if (v > ACC_W'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < ACC_W'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = WORD_W'(v);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      limit_in  = limit_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_IMAGE_WIDTH:     width_in  = csr_pwdata[CFG_DIM_W-1:0];
            REG_IMAGE_HEIGHT:    height_in = csr_pwdata[CFG_DIM_W-1:0];
            REG_ITERATION_LIMIT: limit_in  = csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_IMAGE_WIDTH:     csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT:    csr_prdata = CSR_DATA_W'(height_ff);
         REG_ITERATION_LIMIT: csr_prdata = CSR_DATA_W'(limit_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------- coordinate divide
   assign width_c  = clamp_dim(width_ff);
   assign height_c = clamp_dim(height_ff);

   // real axis is started straight from the request, imaginary from row_ff
   assign div_pix = (state_ff == S_IDLE) ? req_pixel.pixel_column : row_ff;
   assign div_dim = (state_ff == S_IDLE) ? width_c : height_c;
   assign diff    = $signed(DIFF_W'({div_pix, 1'b0}) - DIFF_W'(div_dim));

   assign div_req.start   = div_start;
   assign div_req.neg     = diff[DIFF_W-1];
   assign div_req.mag     = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
   assign div_req.divisor = width_c;

   mandel_coord_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------- shared multiplier
   // RR: zre*zre, II: zim*zim, RI: zre*zim, ZI: next zre*zre
   assign op_a = (state_ff == S_II) ? zim_ff : zre_ff;
   assign op_b = (state_ff == S_II || state_ff == S_RI) ? zim_ff : zre_ff;
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // floor shifts are plain upper slices of the product
   assign ii = $signed(prod_ff[PROD_W-1:FRACTION_BITS]);
   assign ri = $signed(prod_ff[PROD_W-1:FRACTION_BITS-1]);

   assign mag_sq  = ACC_W'(rr_ff) + ACC_W'(ii);
   assign escape  = (mag_sq >= ESCAPE_BOUND);
   assign zre_sum = ACC_W'(rr_ff) - ACC_W'(ii) + ACC_W'(cre_ff);
   assign zim_sum = ACC_W'(ri) + ACC_W'(cim_ff);

   // --------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      cre_in        = cre_ff;
      cim_in        = cim_ff;
      zre_in        = zre_ff;
      zim_in        = zim_ff;
      rr_in         = rr_ff;
      count_in      = count_ff;
      pal_in        = pal_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               row_in    = req_pixel.pixel_row;
               div_start = 1'b1;
               state_in  = S_DIV_RE;
            end
         end
         S_DIV_RE: begin
            if (div_rsp.done) begin
               cre_in    = div_rsp.quotient;
               div_start = 1'b1;
               state_in  = S_DIV_IM;
            end
         end
         S_DIV_IM: begin
            if (div_rsp.done) begin
               cim_in   = div_rsp.quotient;
               zre_in   = '0;
               zim_in   = '0;
               count_in = '0;
               pal_in   = '0;
               state_in = (limit_ff == '0) ? S_DONE : S_RR;
            end
         end
         S_RR: begin
            state_in = S_II;
         end
         S_II: begin
            rr_in    = $signed(prod_ff[PROD_W-1:FRACTION_BITS]);
            state_in = S_RI;
         end
         S_RI: begin
            if (escape) begin
               state_in = S_DONE;
            end else begin
               zre_in   = sat_word(zre_sum);
               count_in = count_ff + COUNT_W'(1);
               pal_in   = (pal_ff == PAL_W'(PALETTE_LEN - 1)) ? '0 : pal_ff + PAL_W'(1);
               state_in = S_ZI;
            end
         end
         S_ZI: begin
            zim_in   = sat_word(zim_sum);
            state_in = (count_ff < limit_ff) ? S_II : S_DONE;
         end
         S_DONE: begin
            rsp_result_in.iteration_count = count_ff;
            rsp_result_in.glyph = (count_ff == limit_ff) ? GLYPH_SPACE
                                                         : palette_glyph(pal_ff);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RST_IMAGE_WIDTH;
         height_ff    <= RST_IMAGE_HEIGHT;
         limit_ff     <= RST_ITERATION_LIMIT;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         limit_ff     <= limit_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff        <= row_in;
      cre_ff        <= cre_in;
      cim_ff        <= cim_in;
      zre_ff        <= zre_in;
      zim_ff        <= zim_in;
      rr_ff         <= rr_in;
      prod_ff       <= prod_in;
      count_ff      <= count_in;
      pal_ff        <= pal_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // --------------------------------------------------------------- assertions
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_RE || state_ff == S_DIV_IM))
      else $error("divider finished outside a divide state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ZI) |-> (count_ff != '0 && count_ff <= limit_ff))
      else $error("iteration count out of range");

   a_ri_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RI) |=> (state_ff == S_ZI || state_ff == S_DONE))
      else $error("bad sequencer step after cross product");

endmodule
